### rtl/cbpe_pkg.sv
// Shared types and constants for the cubic Bezier point evaluator.
// No dependencies; used by cbpe_div and cubic_bezier_point_eval_top.
package cbpe_pkg;

  localparam int unsigned VTX_W     = 16;  // vertex index and count fields
  localparam int unsigned COORD_W   = 24;  // signed Q15.8 coordinates
  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned CFG_IDX_W = 3;

  localparam int unsigned INDEX_BITS_DEF  = 16;
  localparam int unsigned T_FRAC_BITS_DEF = 16;

  // Quotient bits resolved by each stage of the pipelined divider.
  localparam int unsigned DIV_STEPS = 4;

  localparam int COORD_MAX = 8388607;
  localparam int COORD_MIN = -8388608;

  // Register map.
  localparam logic [CFG_IDX_W-1:0] REG_START_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_CTRL_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_CTRL_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_CTRL_X  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_CTRL_Y  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_X       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_Y       = 3'd7;

  // Control points in curve order, one table per axis.
  localparam logic [CFG_IDX_W-1:0] REG_X_OF [4] =
    '{REG_START_X, REG_START_CTRL_X, REG_DEST_CTRL_X, REG_DEST_X};
  localparam logic [CFG_IDX_W-1:0] REG_Y_OF [4] =
    '{REG_START_Y, REG_START_CTRL_Y, REG_DEST_CTRL_Y, REG_DEST_Y};

  // How the curve parameter is obtained for a request.
  typedef enum logic [1:0] {
    SEL_DIV,   // t is the divider quotient
    SEL_ZERO,  // fewer than two samples
    SEL_ONE    // index at or beyond the last sample
  } t_sel_e;

  // Side information that travels through the divider with each request.
  typedef struct packed {
    t_sel_e            sel;
    logic [VTX_W-1:0]  idx;
  } div_tag_t;

endpackage

### rtl/cbpe_div.sv
// Pipelined restoring divider producing the curve parameter quotient.
// Depends on cbpe_pkg for DIV_STEPS and the side-information struct.
module cbpe_div #(
  parameter int unsigned IW = cbpe_pkg::INDEX_BITS_DEF,
  parameter int unsigned QW = cbpe_pkg::T_FRAC_BITS_DEF + 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [IW+QW-1:0]   dividend_i,
  input  logic [IW-1:0]      divisor_i,
  input  cbpe_pkg::div_tag_t tag_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [QW-1:0]      quot_o,
  output cbpe_pkg::div_tag_t tag_o
);
  import cbpe_pkg::*;

  localparam int unsigned NS = (QW + DIV_STEPS - 1) / DIV_STEPS;

  logic           valid_q [NS];
  logic           en      [NS];
  logic [IW-1:0]  rem_q   [NS];
  logic [QW-1:0]  dq_q    [NS];
  logic [IW-1:0]  dsr_q   [NS];
  div_tag_t       tag_q   [NS];

  // A stage advances when it is empty or its successor advances.
  always_comb begin
    en[NS-1] = !valid_q[NS-1] || out_ready_i;
    for (int s = int'(NS) - 2; s >= 0; s--) begin
      en[s] = !valid_q[s] || en[s+1];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[NS-1];
  assign quot_o      = dq_q[NS-1];
  assign tag_o       = tag_q[NS-1];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic          v_in;
    logic [IW-1:0] rem_in;
    logic [QW-1:0] dq_in;
    logic [IW-1:0] dsr_in;
    div_tag_t      tag_in;
    logic [IW-1:0] rem_out;
    logic [QW-1:0] dq_out;

    if (s == 0) begin : g_first
      assign v_in   = in_valid_i;
      assign rem_in = dividend_i[IW+QW-1:QW];
      assign dq_in  = dividend_i[QW-1:0];
      assign dsr_in = divisor_i;
      assign tag_in = tag_i;
    end else begin : g_next
      assign v_in   = valid_q[s-1];
      assign rem_in = rem_q[s-1];
      assign dq_in  = dq_q[s-1];
      assign dsr_in = dsr_q[s-1];
      assign tag_in = tag_q[s-1];
    end

    // The low register shifts dividend bits out at the top and quotient
    // bits in at the bottom, so it ends up holding the quotient.
    always_comb begin
      logic [IW:0] trial;
      logic        qbit;
      rem_out = rem_in;
      dq_out  = dq_in;
      for (int k = 0; k < int'(DIV_STEPS); k++) begin
        if (s * int'(DIV_STEPS) + k < int'(QW)) begin
          trial = {rem_out, dq_out[QW-1]};
          qbit  = (trial >= {1'b0, dsr_in});
          if (qbit) begin
            rem_out = IW'(trial - {1'b0, dsr_in});
          end else begin
            rem_out = trial[IW-1:0];
          end
          dq_out = {dq_out[QW-2:0], qbit};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en[s]) begin
        valid_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[s]) begin
        rem_q[s] <= rem_out;
        dq_q[s]  <= dq_out;
        dsr_q[s] <= dsr_in;
        tag_q[s] <= tag_in;
      end
    end
  end

endmodule

### rtl/cubic_bezier_point_eval_top.sv
// Cubic Bezier point evaluator, top level: registers, input stage, weights, sums.
// Depends on cbpe_pkg and instantiates the pipelined divider cbpe_div.
//
// Usage. The four control points are written through the configuration
// channel (cfg_valid_i/cfg_ready_o, index and 24-bit Q15.8 data) while the
// block is idle; cfg_ready_o is always high. Each request on the slave
// stream carries a vertex index and count; the block forms t = index/(count-1)
// in Q1.T_FRAC_BITS, the four Bernstein weights and the rounded, saturated
// point, and returns it on the master stream with the index echoed.
// The pipeline is one input stage, the divider resolving four quotient bits per
// stage, and nine stages of squaring, cubing, weighting, multiplying and summing.
// Throughput is one request per cycle while the receiver does not stall.
// Every stage holds its own valid bit.
// When the receiver stalls, results stay in place and empty stages still
// fill, so new requests are taken until the whole pipeline is occupied.
// Reset clears the control points to zero and empties the pipeline.
module cubic_bezier_point_eval_top #(
  parameter int unsigned INDEX_BITS  = cbpe_pkg::INDEX_BITS_DEF,
  parameter int unsigned T_FRAC_BITS = cbpe_pkg::T_FRAC_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Configuration write channel.
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [cbpe_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic signed [cbpe_pkg::COORD_W-1:0]    cfg_data_i,
  // Request stream.
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [15:0] vertex_index, [31:16] vertex_count
  input  logic [2*cbpe_pkg::VTX_W-1:0]           s_axis_tdata,
  // Result stream.
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // [23:0] point_x, [47:24] point_y, [63:48] sample_index
  output logic [2*cbpe_pkg::COORD_W+cbpe_pkg::VTX_W-1:0] m_axis_tdata
);
  import cbpe_pkg::*;

  localparam int unsigned F   = T_FRAC_BITS;
  // The index field is 16 bits wide, so masking beyond that changes nothing.
  localparam int unsigned IW  = (INDEX_BITS < VTX_W) ? INDEX_BITS : VTX_W;
  localparam int unsigned TW  = F + 1;          // t and u, 0 .. 2^F
  localparam int unsigned QW  = TW;             // quotient can reach 2^F
  localparam int unsigned DW  = IW + QW;        // dividend
  localparam int unsigned SQW = 2 * TW;         // products of two TW values
  localparam int unsigned WW  = F + 2;          // Bernstein weights
  localparam int unsigned PW  = WW + 1 + COORD_W;
  localparam int unsigned SW  = PW + 2;         // sum of four products
  localparam int unsigned RW  = SW - F;         // sum after the final shift
  localparam int unsigned NST = 10;             // input stage + nine after divider

  localparam logic [TW-1:0]         T_ONE   = TW'(1) << F;
  localparam logic [SQW-1:0]        HALF_SQ = SQW'(1) << (F - 1);
  localparam logic signed [SW-1:0]  HALF_S  = SW'(1) << (F - 1);
  localparam logic signed [RW-1:0]  SAT_MAX = RW'(COORD_MAX);
  localparam logic signed [RW-1:0]  SAT_MIN = RW'(COORD_MIN);

  // ---------------------------------------------------------------------------
  // Control point registers
  // ---------------------------------------------------------------------------
  logic signed [COORD_W-1:0] coord_q [NUM_REGS];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(NUM_REGS); i++) begin
        coord_q[i] <= '0;
      end
    end else if (cfg_valid_i && cfg_ready_o) begin
      coord_q[cfg_index_i] <= cfg_data_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage handshake: a stage advances when it is empty or its successor does.
  // Stage 0 feeds the divider; stages 1 to 9 follow it.
  // ---------------------------------------------------------------------------
  logic [NST-1:0] valid_q;
  logic [NST-1:0] en;
  logic           div_in_ready;
  logic           div_out_valid;
  logic [QW-1:0]  div_quot;
  div_tag_t       div_tag;

  always_comb begin
    en[NST-1] = !valid_q[NST-1] || m_axis_tready;
    for (int k = int'(NST) - 2; k >= 1; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
    en[0] = !valid_q[0] || div_in_ready;
  end

  assign s_axis_tready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= s_axis_tvalid;
      end
      if (en[1]) begin
        valid_q[1] <= div_out_valid;
      end
      for (int k = 2; k < int'(NST); k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: decode the request. A count below two forces t to zero, an index
  // at or past the last sample forces t to one; otherwise the divider forms
  // (index * 2^F + floor(n/2)) / n with n = count - 1.
  // ---------------------------------------------------------------------------
  logic [IW-1:0] in_idx;
  logic [IW-1:0] in_cnt;
  logic [IW-1:0] in_n;
  logic [DW-1:0] in_dividend;
  t_sel_e        in_sel;

  assign in_idx      = s_axis_tdata[IW-1:0];
  assign in_cnt      = s_axis_tdata[VTX_W +: IW];
  assign in_n        = in_cnt - IW'(1);
  assign in_dividend = (DW'(in_idx) << F) + DW'(in_n >> 1);

  always_comb begin
    if (in_cnt < IW'(2)) begin
      in_sel = SEL_ZERO;
    end else if (in_idx >= in_n) begin
      in_sel = SEL_ONE;
    end else begin
      in_sel = SEL_DIV;
    end
  end

  logic [DW-1:0] dvd_q;
  logic [IW-1:0] dsr_q;
  div_tag_t      tag0_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      dvd_q      <= in_dividend;
      dsr_q      <= in_n;
      tag0_q.sel <= in_sel;
      tag0_q.idx <= VTX_W'(in_idx);
    end
  end

  cbpe_div #(
    .IW (IW),
    .QW (QW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (valid_q[0]),
    .in_ready_o  (div_in_ready),
    .dividend_i  (dvd_q),
    .divisor_i   (dsr_q),
    .tag_i       (tag0_q),
    .out_valid_o (div_out_valid),
    .out_ready_i (en[1]),
    .quot_o      (div_quot),
    .tag_o       (div_tag)
  );

  // ---------------------------------------------------------------------------
  // Stages 1 to 5: curve parameter, squares, rounded squares, cubes, weights.
  // ---------------------------------------------------------------------------
  logic [TW-1:0]    t_d;
  logic [TW-1:0]    u_d;
  logic [TW-1:0]    t_q, u_q;      // stage 1
  logic [TW-1:0]    t2s_q, u2s_q;  // stage 2 copies of t and u
  logic [SQW-1:0]   tt_q, uu_q;    // stage 2
  logic [TW-1:0]    t3s_q, u3s_q;  // stage 3 copies
  logic [TW-1:0]    t2_q, u2_q;    // stage 3
  logic [SQW-1:0]   uu_rnd, tt_rnd;
  logic [SQW-1:0]   cu_d [4];
  logic [SQW-1:0]   cu_q [4];      // stage 4
  logic [WW-1:0]    w_d  [4];
  logic [WW-1:0]    w_q  [4];      // stage 5
  logic [VTX_W-1:0] echo_q [1:NST-1];

  always_comb begin
    case (div_tag.sel)
      SEL_ZERO: t_d = '0;
      SEL_ONE:  t_d = T_ONE;
      SEL_DIV:  t_d = div_quot;
      default:  t_d = div_quot;
    endcase
    u_d = T_ONE - t_d;
  end

  assign uu_rnd = uu_q + HALF_SQ;
  assign tt_rnd = tt_q + HALF_SQ;

  always_comb begin
    cu_d[0] = u2_q * u3s_q;
    cu_d[1] = u2_q * t3s_q;
    cu_d[2] = u3s_q * t2_q;
    cu_d[3] = t2_q * t3s_q;
  end

  // The two middle weights carry the factor three before rounding.
  always_comb begin
    logic [SQW-1:0] scaled;
    for (int k = 0; k < 4; k++) begin
      if (k == 1 || k == 2) begin
        scaled = (cu_q[k] << 1) + cu_q[k] + HALF_SQ;
      end else begin
        scaled = cu_q[k] + HALF_SQ;
      end
      w_d[k] = scaled[F+WW-1:F];
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 6 to 9: weighted control points, pairwise sums, final sum with the
  // rounding half, then floor shift and saturation into the output register.
  // ---------------------------------------------------------------------------
  logic signed [PW-1:0]      prod_d [2][4];
  logic signed [PW-1:0]      prod_q [2][4];  // stage 6
  logic signed [SW-1:0]      ps_q   [2][2];  // stage 7
  logic signed [SW-1:0]      sum_q  [2];     // stage 8
  logic signed [RW-1:0]      sh     [2];
  logic signed [COORD_W-1:0] pt_d   [2];
  logic signed [COORD_W-1:0] pt_q   [2];     // stage 9

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      prod_d[0][k] = $signed({1'b0, w_q[k]}) * coord_q[REG_X_OF[k]];
      prod_d[1][k] = $signed({1'b0, w_q[k]}) * coord_q[REG_Y_OF[k]];
    end
  end

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      sh[a] = $signed(sum_q[a][SW-1:F]);
      if (sh[a] > SAT_MAX) begin
        pt_d[a] = COORD_W'(COORD_MAX);
      end else if (sh[a] < SAT_MIN) begin
        pt_d[a] = COORD_W'(COORD_MIN);
      end else begin
        pt_d[a] = sh[a][COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      t_q       <= t_d;
      u_q       <= u_d;
      echo_q[1] <= div_tag.idx;
    end
    if (en[2]) begin
      tt_q      <= t_q * t_q;
      uu_q      <= u_q * u_q;
      t2s_q     <= t_q;
      u2s_q     <= u_q;
      echo_q[2] <= echo_q[1];
    end
    if (en[3]) begin
      t2_q      <= tt_rnd[F+TW-1:F];
      u2_q      <= uu_rnd[F+TW-1:F];
      t3s_q     <= t2s_q;
      u3s_q     <= u2s_q;
      echo_q[3] <= echo_q[2];
    end
    if (en[4]) begin
      cu_q      <= cu_d;
      echo_q[4] <= echo_q[3];
    end
    if (en[5]) begin
      w_q       <= w_d;
      echo_q[5] <= echo_q[4];
    end
    if (en[6]) begin
      prod_q    <= prod_d;
      echo_q[6] <= echo_q[5];
    end
    if (en[7]) begin
      for (int a = 0; a < 2; a++) begin
        ps_q[a][0] <= SW'(prod_q[a][0]) + SW'(prod_q[a][1]);
        ps_q[a][1] <= SW'(prod_q[a][2]) + SW'(prod_q[a][3]);
      end
      echo_q[7] <= echo_q[6];
    end
    if (en[8]) begin
      for (int a = 0; a < 2; a++) begin
        sum_q[a] <= ps_q[a][0] + ps_q[a][1] + HALF_S;
      end
      echo_q[8] <= echo_q[7];
    end
    if (en[9]) begin
      pt_q      <= pt_d;
      echo_q[9] <= echo_q[8];
    end
  end

  assign m_axis_tvalid = valid_q[NST-1];
  assign m_axis_tdata  = {echo_q[NST-1], pt_q[1], pt_q[0]};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  logic [WW+1:0] w_sum;
  assign w_sum = (WW+2)'(w_q[0]) + (WW+2)'(w_q[1]) + (WW+2)'(w_q[2]) + (WW+2)'(w_q[3]);

  // A genuine division never yields a parameter above one.
  a_quot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_out_valid && div_tag.sel == SEL_DIV) |-> (div_quot <= T_ONE))
    else $error("divider quotient exceeds one");

  // Rounded weights stay within a few units of one.
  a_weight_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[5] |-> ((w_sum <= (WW+2)'(T_ONE) + (WW+2)'(4)) &&
                    (w_sum + (WW+2)'(4) >= (WW+2)'(T_ONE))))
    else $error("Bernstein weights do not sum to one");

  // New requests are only refused while a result is waiting at the output.
  a_no_idle_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("request refused with an empty output");

endmodule

### verif/cbpe_point_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the cubic Bezier point evaluator: watches the configuration, request and
// result channels, predicts each point and compares it field by field. Depends on cbpe_pkg.
module cbpe_point_checker (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           cfg_valid_i,
  input  logic                                           cfg_ready_i,
  input  logic [cbpe_pkg::CFG_IDX_W-1:0]                 cfg_index_i,
  input  logic signed [cbpe_pkg::COORD_W-1:0]            cfg_data_i,
  input  logic                                           s_valid_i,
  input  logic                                           s_ready_i,
  input  logic [2*cbpe_pkg::VTX_W-1:0]                   s_data_i,
  input  logic                                           m_valid_i,
  input  logic                                           m_ready_i,
  input  logic [2*cbpe_pkg::COORD_W+cbpe_pkg::VTX_W-1:0] m_data_i,
  output int                                             mismatches_o,
  output int                                             outstanding_o,
  output int                                             compared_o
);
  import cbpe_pkg::*;

  localparam int unsigned     FRAC = T_FRAC_BITS_DEF;
  localparam longint unsigned ONE  = 64'd1 << FRAC;
  localparam longint unsigned HALF = 64'd1 << (FRAC - 1);

  typedef logic signed [COORD_W-1:0] coord_t;

  // Packed from the top bit down, so point_x lands in the lowest bits of tdata.
  typedef struct packed {
    logic [VTX_W-1:0] idx;
    coord_t           y;
    coord_t           x;
  } curve_point_t;

  coord_t       ctrl_reg [NUM_REGS] = '{default: '0};
  curve_point_t expected_points [$];
  int           errors  = 0;
  int           checked = 0;

  function automatic longint unsigned round_frac(input longint unsigned v);
    return (v + HALF) >> FRAC;
  endfunction

  function automatic coord_t clamp_coord(input longint s);
    longint q;
    q = (s + longint'(HALF)) >>> FRAC;
    if (q > longint'(COORD_MAX)) q = longint'(COORD_MAX);
    if (q < longint'(COORD_MIN)) q = longint'(COORD_MIN);
    return q[COORD_W-1:0];
  endfunction

  function automatic curve_point_t bezier_point(input logic [VTX_W-1:0] idx,
                                                input logic [VTX_W-1:0] cnt);
    longint unsigned t, u, u2, t2, n;
    longint unsigned w [4];
    longint          sum_x, sum_y;
    curve_point_t    p;
    if (cnt < 2) begin
      t = 0;
    end else begin
      n = 64'(cnt) - 1;
      if (64'(idx) >= n) t = ONE;
      else t = ((64'(idx) << FRAC) + (n >> 1)) / n;
    end
    u    = ONE - t;
    u2   = round_frac(u * u);
    t2   = round_frac(t * t);
    w[0] = round_frac(u2 * u);
    w[1] = round_frac(3 * u2 * t);
    w[2] = round_frac(3 * u * t2);
    w[3] = round_frac(t2 * t);
    sum_x = 0;
    sum_y = 0;
    for (int k = 0; k < 4; k++) begin
      sum_x += longint'(w[k]) * longint'(ctrl_reg[REG_X_OF[k]]);
      sum_y += longint'(w[k]) * longint'(ctrl_reg[REG_Y_OF[k]]);
    end
    p.x   = clamp_coord(sum_x);
    p.y   = clamp_coord(sum_y);
    p.idx = idx;
    return p;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    curve_point_t got, want;
    if (!rst_ni) begin
      ctrl_reg = '{default: '0};
      expected_points.delete();
      outstanding_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) ctrl_reg[cfg_index_i] = cfg_data_i;
      // Results are checked before new requests are queued, so a result can never
      // match a request taken on the same edge.
      if (m_valid_i && m_ready_i) begin
        got = m_data_i;
        if (expected_points.size() == 0) begin
          errors++;
          $error("point result 0x%h arrived with no request outstanding", got);
        end else begin
          want = expected_points.pop_front();
          checked++;
          if (got.x !== want.x) begin
            errors++;
            $error("point_x: expected %0d, actual %0d", want.x, $signed(got.x));
          end
          if (got.y !== want.y) begin
            errors++;
            $error("point_y: expected %0d, actual %0d", want.y, $signed(got.y));
          end
          if (got.idx !== want.idx) begin
            errors++;
            $error("sample_index: expected %0d, actual %0d", want.idx, got.idx);
          end
        end
      end
      if (s_valid_i && s_ready_i)
        expected_points.push_back(bezier_point(s_data_i[VTX_W-1:0],
                                               s_data_i[2*VTX_W-1:VTX_W]));
      outstanding_o <= expected_points.size();
    end
    mismatches_o <= errors;
    compared_o   <= checked;
  end

endmodule

### verif/cubic_bezier_point_eval_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for cubic_bezier_point_eval_top: clock, reset, stimulus and the verdict.
// Depends on cbpe_pkg, the evaluator RTL and the scoreboard in cbpe_point_checker.sv.
module cubic_bezier_point_eval_top_tb;
  import cbpe_pkg::*;

  typedef logic signed [COORD_W-1:0] coord_t;

  // Pipeline depth with the default parameters; used for the settle time before
  // reprogramming the curve and for the drain at the end of the run.
  localparam int PIPE_LATENCY  = 10 + (T_FRAC_BITS_DEF + 1 + 3) / 4;
  localparam int RANDOM_CURVES = 8;
  localparam int PER_CURVE     = 180;
  localparam int IDLE_PERCENT  = 32;

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [CFG_IDX_W-1:0]       cfg_index_i = '0;
  coord_t                     cfg_data_i = '0;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic [2*VTX_W-1:0]         s_axis_tdata = '0;   // [15:0] vertex_index, [31:16] vertex_count
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  // [23:0] point_x, [47:24] point_y, [63:48] sample_index
  logic [2*COORD_W+VTX_W-1:0] m_axis_tdata;

  // While steady is high neither side inserts bubbles, giving a stretch of
  // back-to-back traffic through the full pipeline.
  logic steady = 1'b0;

  int mismatches, outstanding, compared;
  int requests_sent = 0;
  int curves_loaded = 0;

  always #2 clk_i = ~clk_i;

  cubic_bezier_point_eval_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  cbpe_point_checker scoreboard (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_valid_i     (s_axis_tvalid),
    .s_ready_i     (s_axis_tready),
    .s_data_i      (s_axis_tdata),
    .m_valid_i     (m_axis_tvalid),
    .m_ready_i     (m_axis_tready),
    .m_data_i      (m_axis_tdata),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding),
    .compared_o    (compared)
  );

  // The result side stalls at random, so back-pressure reaches every stage of the
  // pipeline and results pile up behind a held output.
  always @(posedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
  end

  // Offers one request and returns at the edge where it is taken. Ready is looked at
  // on the falling edge, when the block's outputs have long settled.
  task automatic send_vertex(input logic [VTX_W-1:0] idx, input logic [VTX_W-1:0] cnt);
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {cnt, idx};
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    requests_sent++;
  endtask

  // Random request, mostly well-formed samples along a curve of modest length, with
  // the saturating corner, the degenerate counts and raw full-range values mixed in.
  task automatic send_random_vertex();
    logic [VTX_W-1:0] idx, cnt;
    int unsigned      pick;
    pick = $urandom_range(99);
    if (pick < 55) begin
      cnt = VTX_W'($urandom_range(400, 2));
      idx = VTX_W'($urandom_range(cnt - VTX_W'(2)));
    end else if (pick < 68) begin
      cnt = VTX_W'($urandom_range(400, 2));
      idx = cnt - VTX_W'(2) + VTX_W'($urandom_range(3));
    end else if (pick < 76) begin
      cnt = VTX_W'($urandom_range(1));
      idx = VTX_W'($urandom);
    end else begin
      cnt = VTX_W'($urandom);
      idx = VTX_W'($urandom);
    end
    send_vertex(idx, cnt);
  endtask

  // The configuration valid stays high across consecutive writes and is only
  // dropped once the whole curve has been loaded.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input coord_t val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
  endtask

  task automatic load_curve(input coord_t xs [4], input coord_t ys [4]);
    for (int k = 0; k < 4; k++) begin
      write_reg(REG_X_OF[k], xs[k]);
      write_reg(REG_Y_OF[k], ys[k]);
    end
    cfg_valid_i <= 1'b0;
    curves_loaded++;
  endtask

  // Stops offering requests, waits for every outstanding point and then lets the
  // pipeline run empty before the control points may change.
  task automatic drain_pipeline();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 5) @(posedge clk_i);
  endtask

  initial begin
    coord_t xs [4];
    coord_t ys [4];
    rst_ni <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Control points straight out of reset are all zero, so every point is the origin.
    send_vertex(16'd0, 16'd0);
    send_vertex(16'd3, 16'd7);
    send_vertex(16'hFFFF, 16'hFFFF);
    send_vertex(16'd1, 16'd2);
    drain_pipeline();

    // Directed part on a lopsided curve with both coordinate extremes present, so
    // that each weight shows up distinctly in the sum.
    xs = '{-24'sd256000, 24'sd1234567, -24'sd2345678, 24'sd3456789};
    ys = '{24'sd8388607, -24'sd8388608, 24'sd100, -24'sd77777};
    load_curve(xs, ys);
    // Fewer than two samples: the start point whatever the index.
    send_vertex(16'd0, 16'd0);
    send_vertex(16'd0, 16'd1);
    send_vertex(16'd5, 16'd0);
    send_vertex(16'hFFFF, 16'd1);
    // Two samples: the two ends, and an index far past the last one saturating.
    send_vertex(16'd0, 16'd2);
    send_vertex(16'd1, 16'd2);
    send_vertex(16'hFFFF, 16'd2);
    // Longest curve: both ends, the first steps and the middle.
    send_vertex(16'd0, 16'hFFFF);
    send_vertex(16'd1, 16'hFFFF);
    send_vertex(16'h7FFF, 16'hFFFF);
    send_vertex(16'h8000, 16'hFFFF);
    send_vertex(16'hFFFD, 16'hFFFF);
    send_vertex(16'hFFFE, 16'hFFFF);
    send_vertex(16'hFFFF, 16'hFFFF);
    // Short curves where the division rounds, and alternating bit patterns.
    send_vertex(16'd1, 16'd3);
    send_vertex(16'd1, 16'd4);
    send_vertex(16'd2, 16'd4);
    send_vertex(16'd3, 16'd4);
    send_vertex(16'd50, 16'd101);
    send_vertex(16'd2, 16'd7);
    send_vertex(16'h5555, 16'hAAAA);
    send_vertex(16'hAAAA, 16'h5555);
    drain_pipeline();

    // Random part: a fresh curve per batch. The first two put every point at one extreme,
    // where the slight excess of rounded weights forces saturation; the third mixes both.
    for (int p = 0; p < RANDOM_CURVES; p++) begin
      foreach (xs[k]) begin
        case (p)
          0: begin
            xs[k] = coord_t'(COORD_MAX);
            ys[k] = coord_t'(COORD_MAX);
          end
          1: begin
            xs[k] = coord_t'(COORD_MIN);
            ys[k] = coord_t'(COORD_MIN);
          end
          2: begin
            xs[k] = k[0] ? coord_t'(COORD_MIN) : coord_t'(COORD_MAX);
            ys[k] = k[0] ? coord_t'(COORD_MAX) : coord_t'(COORD_MIN);
          end
          5: begin
            xs[k] = coord_t'($urandom_range(8191)) - 24'sd4096;
            ys[k] = coord_t'($urandom_range(8191)) - 24'sd4096;
          end
          default: begin
            xs[k] = coord_t'($urandom);
            ys[k] = coord_t'($urandom);
          end
        endcase
      end
      load_curve(xs, ys);
      steady <= (p == 4);
      repeat (PER_CURVE) send_random_vertex();
      drain_pipeline();
    end
    steady <= 1'b0;

    $display("Summary: %0d requests on %0d curve settings, %0d points compared.",
             requests_sent, curves_loaded, compared);
    if (mismatches == 0) begin
      $display("cubic_bezier_point_eval_top_tb: clean");
    end else begin
      $display("cubic_bezier_point_eval_top_tb: errors");
    end
    $finish;
  end

  // Watchdog: a correct run needs well under a tenth of this.
  initial begin
    #2000000;
    $display("Watchdog expired with %0d points outstanding.", outstanding);
    $display("cubic_bezier_point_eval_top_tb: errors");
    $finish;
  end

endmodule

### sim.f
rtl/cbpe_pkg.sv
rtl/cbpe_div.sv
rtl/cubic_bezier_point_eval_top.sv
verif/cbpe_point_checker.sv
verif/cubic_bezier_point_eval_top_tb.sv
